// ===== sv/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants of the LRU frame replacer
// Field widths, operation codes and the item and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

	localparam int unsigned FRAME_W        = 6;
	localparam int unsigned FRAME_SPAN     = 2 ** FRAME_W;
	localparam int unsigned MODE_W         = 2;
	localparam int unsigned COUNT_W        = 7;
	localparam int unsigned NUM_FRAMES_DEF = 64;
	localparam int unsigned S_TDATA_W      = 8;
	localparam int unsigned M_TDATA_W      = 16;

	// operation codes carried in the item's mode field; the fourth code is a no-op
	localparam logic [MODE_W-1:0] MODE_EVICT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PIN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UNPIN = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [FRAME_W-1:0] frame;
	} op_t;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] victim;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/lfr_ram.sv =====
// ----------------------------------------------------------------------------
// lfr_ram: generic single write, single read RAM
// One write port, one read port with registered read data (old data on
// a read and write to the same address in the same cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/lfr_list.sv =====
// ----------------------------------------------------------------------------
// lfr_list: doubly linked age list of evictable frames
// Membership flags, end pointers and count in flops; next and prev links in
// RAMs read at lookup time, with forwarding of the update in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_list
	import lfr_pkg::*;
#(
	parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic lookup_en,
	input  wire op_t  lookup_op,
	input  wire logic exec_en,
	input  wire op_t  exec_op,
	output res_t      exec_res
);

	// frame ids are FRAME_W bits wide, so no more than FRAME_SPAN frames are reachable
	localparam int unsigned NUM_SLOTS = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
	localparam int unsigned IDX_W     = $clog2(NUM_SLOTS);
	localparam int unsigned CNT_W     = $clog2(NUM_SLOTS + 1);

	typedef logic [IDX_W-1:0] idx_t;

	logic [NUM_SLOTS-1:0] member_q, member_d;
	idx_t                 oldest_q, oldest_d;
	idx_t                 newest_q, newest_d;
	logic [CNT_W-1:0]     count_q, count_d;

	logic next_we, prev_we;
	idx_t next_waddr, next_wdata, prev_waddr, prev_wdata;
	idx_t next_raddr, prev_raddr, next_rd, prev_rd;
	logic next_fwd_s1, prev_fwd_s1;
	idx_t next_fwd_data_s1, prev_fwd_data_s1;
	idx_t next_link, prev_link;

	logic in_range, do_drop, do_add;
	idx_t f_idx, drop_idx;

	// evict reads the successor of the oldest frame as it stands once the
	// item now executing has committed
	assign next_raddr = (lookup_op.mode == MODE_EVICT) ? oldest_d : idx_t'(lookup_op.frame);
	assign prev_raddr = idx_t'(lookup_op.frame);

	lfr_ram #(
		.WIDTH (IDX_W),
		.DEPTH (NUM_SLOTS)
	) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (lookup_en),
		.raddr (next_raddr),
		.rdata (next_rd)
	);

	lfr_ram #(
		.WIDTH (IDX_W),
		.DEPTH (NUM_SLOTS)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.re    (lookup_en),
		.raddr (prev_raddr),
		.rdata (prev_rd)
	);

	// capture a link write that lands in the same cycle as the lookup
	always_ff @(posedge clk) begin
		if (lookup_en) begin
			next_fwd_s1      <= next_we && (next_waddr == next_raddr);
			next_fwd_data_s1 <= next_wdata;
			prev_fwd_s1      <= prev_we && (prev_waddr == prev_raddr);
			prev_fwd_data_s1 <= prev_wdata;
		end
	end

	assign next_link = next_fwd_s1 ? next_fwd_data_s1 : next_rd;
	assign prev_link = prev_fwd_s1 ? prev_fwd_data_s1 : prev_rd;

	assign in_range = (FRAME_W + 1)'(exec_op.frame) < (FRAME_W + 1)'(NUM_SLOTS);
	assign f_idx    = idx_t'(exec_op.frame);

	always_comb begin
		do_drop  = 1'b0;
		do_add   = 1'b0;
		drop_idx = f_idx;
		unique case (exec_op.mode)
			MODE_EVICT: begin
				do_drop  = exec_en && (count_q != '0);
				drop_idx = oldest_q;
			end
			MODE_PIN: begin
				do_drop = exec_en && in_range && member_q[f_idx];
			end
			MODE_UNPIN: begin
				do_add = exec_en && in_range && !member_q[f_idx];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		member_d   = member_q;
		oldest_d   = oldest_q;
		newest_d   = newest_q;
		count_d    = count_q;
		next_we    = 1'b0;
		next_waddr = '0;
		next_wdata = '0;
		prev_we    = 1'b0;
		prev_waddr = '0;
		prev_wdata = '0;
		if (do_drop) begin
			if (count_q <= CNT_W'(1)) begin
				oldest_d = '0;
				newest_d = '0;
			end else if (drop_idx == oldest_q) begin
				oldest_d = next_link;
			end else if (drop_idx == newest_q) begin
				newest_d = prev_link;
			end else begin
				// unlink from the middle
				next_we    = 1'b1;
				next_waddr = prev_link;
				next_wdata = next_link;
				prev_we    = 1'b1;
				prev_waddr = next_link;
				prev_wdata = prev_link;
			end
			member_d[drop_idx] = 1'b0;
			count_d            = count_q - CNT_W'(1);
		end else if (do_add) begin
			if (count_q == '0) begin
				oldest_d = f_idx;
			end else begin
				next_we    = 1'b1;
				next_waddr = newest_q;
				next_wdata = f_idx;
				prev_we    = 1'b1;
				prev_waddr = f_idx;
				prev_wdata = newest_q;
			end
			newest_d        = f_idx;
			member_d[f_idx] = 1'b1;
			count_d         = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q <= '0;
			oldest_q <= '0;
			newest_q <= '0;
			count_q  <= '0;
		end else begin
			member_q <= member_d;
			oldest_q <= oldest_d;
			newest_q <= newest_d;
			count_q  <= count_d;
		end
	end

	assign exec_res.found  = (exec_op.mode == MODE_EVICT) && (count_q != '0);
	assign exec_res.victim = exec_res.found ? FRAME_W'(oldest_q) : '0;
	assign exec_res.count  = COUNT_W'(count_d);

	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(member_q) == 32'(count_q))
		else $error("tracked count differs from number of member flags");

	a_empty_ends_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (oldest_q == '0) && (newest_q == '0))
		else $error("empty list with nonzero end pointers");

	a_ends_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> member_q[oldest_q] && member_q[newest_q])
		else $error("list end points at an untracked frame");

	a_evict_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		exec_en && (exec_op.mode == MODE_EVICT) && (count_q != '0)
		|=> count_q == $past(count_q) - CNT_W'(1))
		else $error("evict on a nonempty list did not shrink the count");

endmodule

`default_nettype wire

// ===== sv/lru_frame_replacer_unit.sv =====
// ----------------------------------------------------------------------------
// lru_frame_replacer_unit: LRU replacement list of evictable frames
// Stream wrapper around the age-ordered frame list.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on the s_ group is one operation: mode in s_tuser
//   (evict oldest, pin frame, unpin frame, fourth code a no-op) and the frame
//   number in s_tdata. Each operation yields exactly one result transaction
//   on the m_ group: victim_found in m_tuser, victim_frame and tracked_count
//   in m_tdata.
//   An input transaction is registered into the operation stage, which also
//   issues the link RAM lookups; when that stage fires, the list update
//   commits and the result is registered, raising m_tvalid.
//   Throughput is one operation per cycle unless the receiver stalls; the link
//   RAMs are read on accept and forward the link written by the operation in
//   flight, so back-to-back operations on the same frames need no bubble.
//   When the receiver stalls, the result register holds and the operation
//   stage holds behind it; s_tready drops only when both are full.
//   Reset clears the membership flags, list pointers and count at once, so
//   the block accepts transactions right after reset; the link RAMs need no
//   clearing since only tracked frames' links are read.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_frame_replacer_unit
	import lfr_pkg::*;
#(
	parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // [5:0] frame, [7:6] zero
	input  wire logic [MODE_W-1:0]    s_tuser,  // [1:0] mode
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,  // [5:0] victim_frame, [12:6] tracked_count,
	                                            // [15:13] zero
	output logic      [0:0]           m_tuser   // [0] victim_found
);

	localparam int unsigned M_PAD_W = M_TDATA_W - FRAME_W - COUNT_W;

	op_t  in_op;
	op_t  op_s1;
	logic valid_s1;
	logic fire_s1;
	logic in_accept;
	res_t res_s1;
	res_t res_q;
	logic out_valid_q;

	assign in_op.mode  = s_tuser;
	assign in_op.frame = s_tdata[FRAME_W-1:0];

	// advance the operation stage whenever the result register is free or being drained
	assign fire_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || fire_s1;
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (fire_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold payload until the next transaction or result
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1 <= in_op;
		end
		if (fire_s1) begin
			res_q <= res_s1;
		end
	end

	lfr_list #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_list (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup_en (in_accept),
		.lookup_op (in_op),
		.exec_en   (fire_s1),
		.exec_op   (op_s1),
		.exec_res  (res_s1)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, res_q.count, res_q.victim};
	assign m_tuser  = res_q.found;

endmodule

`default_nettype wire

// ===== dv/tb_lru_frame_replacer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_frame_replacer_unit: stream-level check of the LRU frame replacer
// Drives evict, pin, unpin and no-op transactions, mirrors the age order of
// tracked frames in a scoreboard and compares every result transaction.
// Sender gaps and receiver stalls come in random bursts, with a calm tail.
// ----------------------------------------------------------------------------

import lfr_pkg::*;

class frame_lru_scoreboard;
	bit [FRAME_W-1:0] age_order[$];          // tracked frames, oldest first
	bit               tracked_flag[FRAME_SPAN];
	res_t             due_results[$];
	int               err_cnt;
	int               op_cnt;
	int               res_cnt;
	int               victim_cnt;
	int               empty_evict_cnt;
	int               peak_count;

	// Apply one accepted operation to the age order and queue its result.
	function void note_op(op_t op);
		res_t r;
		r = '0;
		op_cnt++;
		case (op.mode)
			MODE_EVICT: begin
				if (age_order.size() > 0) begin
					r.found  = 1'b1;
					r.victim = age_order[0];
					age_order.delete(0);
					tracked_flag[r.victim] = 1'b0;
					victim_cnt++;
				end else begin
					empty_evict_cnt++;
				end
			end
			MODE_PIN: begin
				if (tracked_flag[op.frame]) begin
					for (int i = 0; i < age_order.size(); i++) begin
						if (age_order[i] == op.frame) begin
							age_order.delete(i);
							break;
						end
					end
					tracked_flag[op.frame] = 1'b0;
				end
			end
			MODE_UNPIN: begin
				// a frame already tracked keeps its place
				if (!tracked_flag[op.frame]) begin
					age_order.insert(age_order.size(), op.frame);
					tracked_flag[op.frame] = 1'b1;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(age_order.size());
		if (age_order.size() > peak_count)
			peak_count = age_order.size();
		due_results.insert(due_results.size(), r);
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (due_results.size() == 0) begin
			$display("%0t: unexpected result found=%0d victim=%0d count=%0d",
				$time, got.found, got.victim, got.count);
			err_cnt++;
			return;
		end
		want = due_results[0];
		due_results.delete(0);
		res_cnt++;
		if (got.found !== want.found) begin
			$display("%0t: victim_found expected %0d actual %0d",
				$time, want.found, got.found);
			err_cnt++;
		end
		if (got.victim !== want.victim) begin
			$display("%0t: victim_frame expected %0d actual %0d",
				$time, want.victim, got.victim);
			err_cnt++;
		end
		if (got.count !== want.count) begin
			$display("%0t: tracked_count expected %0d actual %0d",
				$time, want.count, got.count);
			err_cnt++;
		end
	endfunction

	function int pending();
		return due_results.size();
	endfunction
endclass

module tb_lru_frame_replacer_unit;

	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
	localparam int RAND_OPS  = 1580;
	localparam int CALM_OPS  = 200;
	localparam int SEG_FILL  = 0;
	localparam int SEG_DRAIN = 1;
	localparam int SEG_CHURN = 2;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [MODE_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;
	bit                   calm = 1'b0;

	frame_lru_scoreboard sb = new();

	// opening sequence: empty list, extremes, repeat unpin, pins at every position
	op_t opening_ops[20] = '{
		{MODE_EVICT, 6'd0},  {MODE_PIN, 6'd5},    {MODE_NOP, 6'd63},  {MODE_UNPIN, 6'd0},
		{MODE_UNPIN, 6'd63}, {MODE_UNPIN, 6'd0},  {MODE_UNPIN, 6'd42}, {MODE_UNPIN, 6'd21},
		{MODE_PIN, 6'd63},   {MODE_PIN, 6'd21},   {MODE_UNPIN, 6'd63}, {MODE_PIN, 6'd0},
		{MODE_NOP, 6'd0},    {MODE_EVICT, 6'd63}, {MODE_EVICT, 6'd0},  {MODE_EVICT, 6'd0},
		{MODE_UNPIN, 6'd7},  {MODE_PIN, 6'd7},    {MODE_EVICT, 6'd0},  {MODE_PIN, 6'd7}
	};

	lru_frame_replacer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sample both groups at the rising edge; check before noting the new operation.
	always @(posedge clk) begin
		res_t got;
		if (m_tvalid && m_tready) begin
			got.found  = m_tuser[0];
			got.victim = m_tdata[FRAME_W-1:0];
			got.count  = m_tdata[FRAME_W +: COUNT_W];
			sb.check_result(got);
		end
		if (s_tvalid && s_tready)
			sb.note_op(op_t'({s_tuser, s_tdata[FRAME_W-1:0]}));
	end

	// Receiver: stall in bursts, ready in stretches, always ready in the calm tail.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 60) - 1) @(negedge clk);
			end
		end
	end

	// Hold one transaction until accepted, then return at the next falling edge.
	task automatic send_op(input op_t op);
		s_tvalid <= 1'b1;
		s_tuser  <= op.mode;
		s_tdata  <= S_TDATA_W'(op.frame);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		s_tvalid <= 1'b0;
		s_tuser  <= MODE_W'($urandom);
		s_tdata  <= S_TDATA_W'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	// Draw a frame, leaning toward tracked ones for pin and untracked ones for unpin.
	function automatic logic [FRAME_W-1:0] pick_frame(input logic [MODE_W-1:0] mode);
		logic [FRAME_W-1:0] f;
		f = FRAME_W'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			if (mode == MODE_PIN && sb.age_order.size() > 0) begin
				f = sb.age_order[$urandom_range(0, sb.age_order.size() - 1)];
			end else if (mode == MODE_UNPIN && sb.age_order.size() < FRAME_SPAN) begin
				while (sb.tracked_flag[f]) f = FRAME_W'($urandom);
			end
		end
		return f;
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(input int seg_kind);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return MODE_NOP;
		case (seg_kind)
			SEG_FILL:  return (roll < 80) ? MODE_UNPIN : (roll < 90) ? MODE_PIN : MODE_EVICT;
			SEG_DRAIN: return (roll < 65) ? MODE_EVICT : (roll < 88) ? MODE_PIN : MODE_UNPIN;
			default:   return (roll < 30) ? MODE_EVICT : (roll < 60) ? MODE_PIN : MODE_UNPIN;
		endcase
	endfunction

	initial begin
		op_t op;
		int  seg_left;
		int  seg_kind;
		int  gap_rate;
		int  spin;
		seg_left = 0;
		seg_kind = SEG_FILL;
		gap_rate = 0;
		spin     = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_ops[i])
			send_op(opening_ops[i]);

		for (int i = 0; i < RAND_OPS; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(40, 140);
				seg_kind = $urandom_range(SEG_FILL, SEG_CHURN);
				gap_rate = $urandom_range(0, 3);
			end
			if (i == RAND_OPS - CALM_OPS)
				calm = 1'b1;
			if (!calm && gap_rate != 0 && $urandom_range(0, 9) < gap_rate)
				idle_sender($urandom_range(1, 17));
			op.mode  = pick_mode(seg_kind);
			op.frame = pick_frame(op.mode);
			send_op(op);
			seg_left--;
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then let the pipeline settle before the final check
		while (sb.pending() != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
			sb.err_cnt++;
		end

		$display("Ran %0d operations: %0d evictions returned a frame, %0d hit an empty list,",
			sb.op_cnt, sb.victim_cnt, sb.empty_evict_cnt);
		$display("peak list occupancy %0d frames; %0d results compared, %0d mismatches.",
			sb.peak_count, sb.res_cnt, sb.err_cnt);
		if (sb.err_cnt == 0)
			$display("[lru_frame_replacer_unit] OK");
		else
			$display("[lru_frame_replacer_unit] ERROR");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2ms;
		$display("[lru_frame_replacer_unit] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lfr_pkg.sv
sv/lfr_ram.sv
sv/lfr_list.sv
sv/lru_frame_replacer_unit.sv
dv/tb_lru_frame_replacer_unit.sv
